// ----- hw/rtl/lfr64_pkg.sv -----
// Shared types for the LSB-first radix-64 codec.
// Used by lfr64_step, lfr64_res_fifo and lsb_first_radix64_codec_top.
package lfr64_pkg;

    localparam int RES_LEVEL_W = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } res_t;

    typedef struct packed {
        logic [1:0] n;
        res_t       res0;
        res_t       res1;
        logic [5:0] buf_next;
        logic [2:0] cnt_next;
    } step_t;

    typedef struct packed {
        logic                   can_push2;
        logic [RES_LEVEL_W-1:0] level;
    } fifo_stat_t;

endpackage

// ----- hw/rtl/lfr64_step.sv -----
// Combinational step of the codec: one held word plus the bit accumulator
// gives up to two results and the next accumulator. Depends on lfr64_pkg.
module lfr64_step (
    input  logic                direction,
    input  logic [7:0]          data_in,
    input  logic                last_in,
    input  logic [5:0]          buf_in,
    input  logic [2:0]          cnt_in,
    output lfr64_pkg::step_t    step
);

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] ASCII_UP_A  = 8'h41;
    localparam logic [7:0] ASCII_UP_Z  = 8'h5A;
    localparam logic [7:0] ASCII_LO_A  = 8'h61;
    localparam logic [7:0] ASCII_LO_Z  = 8'h7A;
    localparam logic [7:0] ASCII_UNDER = 8'h5F;
    localparam logic [7:0] ASCII_EQUAL = 8'h3D;
    localparam logic [5:0] VAL_UP_A    = 6'd10;
    localparam logic [5:0] VAL_LO_A    = 6'd36;
    localparam logic [5:0] VAL_UNDER   = 6'd62;
    localparam logic [5:0] VAL_EQUAL   = 6'd63;

    function automatic logic [7:0] val_to_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < VAL_UP_A) begin
            c = ASCII_ZERO + {2'd0, v};
        end else if (v < VAL_LO_A) begin
            c = ASCII_UP_A + {2'd0, v - VAL_UP_A};
        end else if (v < VAL_UNDER) begin
            c = ASCII_LO_A + {2'd0, v - VAL_LO_A};
        end else if (v == VAL_UNDER) begin
            c = ASCII_UNDER;
        end else begin
            c = ASCII_EQUAL;
        end
        return c;
    endfunction

    // Result bit 6 is set when the character belongs to the alphabet.
    function automatic logic [6:0] char_to_val(input logic [7:0] c);
        logic [7:0] d;
        logic [6:0] r;
        d = 8'd0;
        r = 7'd0;
        if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
            d = c - ASCII_ZERO;
            r = {1'b1, d[5:0]};
        end else if (c >= ASCII_UP_A && c <= ASCII_UP_Z) begin
            d = c - ASCII_UP_A + {2'd0, VAL_UP_A};
            r = {1'b1, d[5:0]};
        end else if (c >= ASCII_LO_A && c <= ASCII_LO_Z) begin
            d = c - ASCII_LO_A + {2'd0, VAL_LO_A};
            r = {1'b1, d[5:0]};
        end else if (c == ASCII_UNDER) begin
            r = {1'b1, VAL_UNDER};
        end else if (c == ASCII_EQUAL) begin
            r = {1'b1, VAL_EQUAL};
        end
        return r;
    endfunction

    logic [14:0] e_acc0, e_acc1, e_acc2;
    logic [3:0]  e_c0, e_c1, e_c2;
    logic        e_two;
    logic [6:0]  d_cv;
    logic [12:0] d_acc, d_acc_sh;
    logic [3:0]  d_c;

    always_comb begin
        step = '0;

        e_acc0 = {9'd0, buf_in} | ({7'd0, data_in} << cnt_in);
        e_c0   = {1'b0, cnt_in} + 4'd8;
        e_acc1 = e_acc0 >> 6;
        e_c1   = e_c0 - 4'd6;
        e_two  = (e_c1 >= 4'd6);
        e_acc2 = e_two ? (e_acc1 >> 6) : e_acc1;
        e_c2   = e_two ? (e_c1 - 4'd6) : e_c1;

        d_cv     = char_to_val(data_in);
        d_acc    = {7'd0, buf_in} | ({7'd0, d_cv[5:0]} << cnt_in);
        d_acc_sh = d_acc >> 8;
        d_c      = {1'b0, cnt_in} + 4'd6;

        if (!direction) begin
            step.res0 = '{data: val_to_char(e_acc0[5:0]), last: 1'b0, err: 1'b0};
            step.res1 = '{data: val_to_char(e_acc1[5:0]), last: 1'b0, err: 1'b0};
            step.n    = e_two ? 2'd2 : 2'd1;
            step.buf_next = e_acc2[5:0];
            step.cnt_next = e_c2[2:0];
            if (last_in) begin
                if (!e_two && e_c2 != 4'd0) begin
                    step.n         = 2'd2;
                    step.res1.last = 1'b1;
                end else if (e_two) begin
                    step.res1.last = 1'b1;
                end else begin
                    step.res0.last = 1'b1;
                end
                step.buf_next = 6'd0;
                step.cnt_next = 3'd0;
            end
        end else begin
            step.res1 = '0;
            if (!d_cv[6]) begin
                step.n    = 2'd1;
                step.res0 = '{data: 8'd0, last: last_in, err: 1'b1};
                step.buf_next = buf_in;
                step.cnt_next = cnt_in;
            end else if (d_c >= 4'd8) begin
                step.n    = 2'd1;
                step.res0 = '{data: d_acc[7:0], last: last_in, err: 1'b0};
                step.buf_next = d_acc_sh[5:0];
                step.cnt_next = 3'(d_c - 4'd8);
            end else begin
                step.n    = last_in ? 2'd1 : 2'd0;
                step.res0 = '{data: 8'd0, last: 1'b1, err: 1'b1};
                step.buf_next = d_acc[5:0];
                step.cnt_next = d_c[2:0];
            end
            if (last_in) begin
                step.buf_next = 6'd0;
                step.cnt_next = 3'd0;
            end
        end
    end

endmodule

// ----- hw/rtl/lfr64_res_fifo.sv -----
// Four-entry result queue: takes up to two results a cycle, hands out one.
// The head entry drives the output channel directly. Depends on lfr64_pkg.
module lfr64_res_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [1:0]              push_n,
    input  lfr64_pkg::res_t         push0,
    input  lfr64_pkg::res_t         push1,
    input  logic                    pop,
    output lfr64_pkg::res_t         head,
    output logic                    head_valid,
    output lfr64_pkg::fifo_stat_t   stat
);

    localparam int DEPTH = 4;

    lfr64_pkg::res_t                   mem_reg [DEPTH];
    logic [1:0]                        wr_ptr_reg, wr_ptr_next;
    logic [1:0]                        rd_ptr_reg, rd_ptr_next;
    logic [lfr64_pkg::RES_LEVEL_W-1:0] level_reg, level_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        level_next  = level_reg + {1'b0, push_n} - {2'd0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2) begin
            mem_reg[wr_ptr_reg + 2'd1] <= push1;
        end
    end

    assign head            = mem_reg[rd_ptr_reg];
    assign head_valid      = (level_reg != '0);
    assign stat.level      = level_reg;
    assign stat.can_push2  = (level_reg <= 3'd2);

endmodule

// ----- hw/rtl/lsb_first_radix64_codec_top.sv -----
// Top level of the LSB-first radix-64 codec: input register, bit accumulator
// and result queue. Depends on lfr64_pkg, lfr64_step and lfr64_res_fifo.
//
//  Channel   Direction  tdata           tlast     tuser
//  s_        in         data_in[7:0]    last      -
//  m_        out        data_out[7:0]   out_last  error
//  cfg_wr_*  in         direction       -         -
//
// A word reaches the input register on acceptance and is processed the next
// cycle when the result queue has room for two results.
// Encoding gives up to two characters per byte on the single output channel,
// four per three bytes, so the output port sets the rate; decoding runs at
// one character per cycle while m_tready holds; results go to the queue.
// Reset is synchronous and active low; it clears the mode and the accumulator.
// Output stalls fill the four-entry result queue; with three or more results
// queued, a waiting word holds off s_tready.
module lsb_first_radix64_codec_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_in
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] data_out
    output logic       m_tlast,
    output logic       m_tuser    // [0] error
);

    logic       dir_reg;
    logic [5:0] buf_reg;
    logic [2:0] cnt_reg;
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       s_acc, fire, pop;

    lfr64_pkg::step_t      step;
    lfr64_pkg::res_t       head;
    lfr64_pkg::fifo_stat_t stat;
    logic                  head_valid;

    lfr64_step u_step (
        .direction (dir_reg),
        .data_in   (in_data_reg),
        .last_in   (in_last_reg),
        .buf_in    (buf_reg),
        .cnt_in    (cnt_reg),
        .step      (step)
    );

    assign fire     = in_vld_reg && stat.can_push2;
    assign s_tready = !in_vld_reg || fire;
    assign s_acc    = s_tvalid && s_tready;
    assign pop      = head_valid && m_tready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_acc) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            dir_reg    <= 1'b0;
            buf_reg    <= '0;
            cnt_reg    <= '0;
        end else begin
            in_vld_reg <= in_vld_next;
            if (cfg_wr_en) begin
                dir_reg <= cfg_wr_data;
                buf_reg <= '0;
                cnt_reg <= '0;
            end else if (fire) begin
                buf_reg <= step.buf_next;
                cnt_reg <= step.cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    lfr64_res_fifo u_res_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_n     (fire ? step.n : 2'd0),
        .push0      (step.res0),
        .push1      (step.res1),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .stat       (stat)
    );

    assign m_tvalid = head_valid;
    assign m_tdata  = head.data;
    assign m_tlast  = head.last;
    assign m_tuser  = head.err;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.level <= 3'd4)
        else $error("result queue level out of range");

    a_enc_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !dir_reg |-> step.n != 2'd0)
        else $error("encode step produced no character");

    a_cnt_even: assert property (@(posedge aclk) disable iff (!aresetn)
        !cnt_reg[0])
        else $error("bit count became odd");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && in_last_reg && !cfg_wr_en |=> cnt_reg == 3'd0 && buf_reg == 6'd0)
        else $error("accumulator not cleared after last word");
`endif

endmodule
